// ----- design/flhe_pkg.sv -----
// Shared types and constants for the fault-line height field engine.
package flhe_pkg;

  localparam int GRID_COLS_DEF = 128;
  localparam int GRID_ROWS_DEF = 128;

  localparam logic [30:0] SPAN_RESET = 31'd8388608;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_FAULT = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] CFG_SPAN_X = 2'd0;
  localparam logic [1:0] CFG_SPAN_Z = 2'd1;

  localparam logic signed [15:0] CELL_MAX = 16'sd32767;
  localparam logic signed [15:0] CELL_MIN = -16'sd32767;

  localparam logic [1:0] RD_CENTER = 2'd0;
  localparam logic [1:0] RD_SECOND = 2'd1;
  localparam logic [1:0] RD_THIRD  = 2'd2;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_FLT, ST_QXL, ST_QX, ST_QZL, ST_QZ, ST_CHK,
    ST_RA, ST_RB, ST_RC, ST_RW, ST_M1, ST_M2, ST_SUM, ST_OUT
  } state_t;

  typedef struct packed {
    logic       latch;
    logic       cnt_clr;
    logic       clr_step;
    logic       flt_step;
    logic       div_load;
    logic       div_sel;
    logic       div_step;
    logic       div_save_x;
    logic       chk;
    logic [1:0] rd_sel;
    logic       cap_hc;
    logic       cap_h2;
    logic       cap_h3;
    logic       mul1;
    logic       mul2;
    logic       sum;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic flt_done;
    logic div_done;
    logic border;
  } sts_t;

endpackage

// ----- design/flhe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module flhe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/flhe_ctrl.sv -----
// Controller state machine: sequences clear, fault and query operations.
module flhe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           op,
  input  flhe_pkg::sts_t       sts,
  output flhe_pkg::cmd_t       cmd,
  output logic                 busy,
  output logic                 out_valid
);

  flhe_pkg::state_t state_r, state_nxt;
  logic res_due_r, res_due_nxt;

  // state and result-due flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= flhe_pkg::ST_CLR;
      res_due_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      res_due_r <= res_due_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt   = state_r;
    res_due_nxt = res_due_r;
    unique case (state_r)
      flhe_pkg::ST_CLR: begin
        if (sts.sweep_last) begin
          state_nxt   = res_due_r ? flhe_pkg::ST_OUT : flhe_pkg::ST_IDLE;
          res_due_nxt = 1'b0;
        end
      end
      flhe_pkg::ST_IDLE: begin
        if (start) begin
          unique case (op)
            flhe_pkg::OP_CLEAR: begin
              state_nxt   = flhe_pkg::ST_CLR;
              res_due_nxt = 1'b1;
            end
            flhe_pkg::OP_FAULT: state_nxt = flhe_pkg::ST_FLT;
            flhe_pkg::OP_QUERY: state_nxt = flhe_pkg::ST_QXL;
            default:            state_nxt = flhe_pkg::ST_OUT;
          endcase
        end
      end
      flhe_pkg::ST_FLT: if (sts.flt_done) state_nxt = flhe_pkg::ST_OUT;
      flhe_pkg::ST_QXL: state_nxt = flhe_pkg::ST_QX;
      flhe_pkg::ST_QX:  if (sts.div_done) state_nxt = flhe_pkg::ST_QZL;
      flhe_pkg::ST_QZL: state_nxt = flhe_pkg::ST_QZ;
      flhe_pkg::ST_QZ:  if (sts.div_done) state_nxt = flhe_pkg::ST_CHK;
      flhe_pkg::ST_CHK: state_nxt = sts.border ? flhe_pkg::ST_OUT : flhe_pkg::ST_RA;
      flhe_pkg::ST_RA:  state_nxt = flhe_pkg::ST_RB;
      flhe_pkg::ST_RB:  state_nxt = flhe_pkg::ST_RC;
      flhe_pkg::ST_RC:  state_nxt = flhe_pkg::ST_RW;
      flhe_pkg::ST_RW:  state_nxt = flhe_pkg::ST_M1;
      flhe_pkg::ST_M1:  state_nxt = flhe_pkg::ST_M2;
      flhe_pkg::ST_M2:  state_nxt = flhe_pkg::ST_SUM;
      flhe_pkg::ST_SUM: state_nxt = flhe_pkg::ST_OUT;
      flhe_pkg::ST_OUT: state_nxt = flhe_pkg::ST_IDLE;
      default:          state_nxt = flhe_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      flhe_pkg::ST_CLR:  cmd.clr_step = 1'b1;
      flhe_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.latch   = start;
        cmd.cnt_clr = start;
      end
      flhe_pkg::ST_FLT:  cmd.flt_step = 1'b1;
      flhe_pkg::ST_QXL:  cmd.div_load = 1'b1;
      flhe_pkg::ST_QX: begin
        cmd.div_step   = !sts.div_done;
        cmd.div_save_x = sts.div_done;
      end
      flhe_pkg::ST_QZL: begin
        cmd.div_load = 1'b1;
        cmd.div_sel  = 1'b1;
      end
      flhe_pkg::ST_QZ:   cmd.div_step = !sts.div_done;
      flhe_pkg::ST_CHK:  cmd.chk = 1'b1;
      flhe_pkg::ST_RA:   cmd.rd_sel = flhe_pkg::RD_CENTER;
      flhe_pkg::ST_RB: begin
        cmd.rd_sel = flhe_pkg::RD_SECOND;
        cmd.cap_hc = 1'b1;
      end
      flhe_pkg::ST_RC: begin
        cmd.rd_sel = flhe_pkg::RD_THIRD;
        cmd.cap_h2 = 1'b1;
      end
      flhe_pkg::ST_RW:   cmd.cap_h3 = 1'b1;
      flhe_pkg::ST_M1:   cmd.mul1 = 1'b1;
      flhe_pkg::ST_M2:   cmd.mul2 = 1'b1;
      flhe_pkg::ST_SUM:  cmd.sum = 1'b1;
      flhe_pkg::ST_OUT:  out_valid = 1'b1;
      default:           busy = 1'b1;
    endcase
  end

endmodule

// ----- design/flhe_dp.sv -----
// Datapath: sweep counters, fault update, divider and triangle interpolation.
module flhe_dp #(
  parameter int GRID_COLS = flhe_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = flhe_pkg::GRID_ROWS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  flhe_pkg::cmd_t                         cmd,
  output flhe_pkg::sts_t                         sts,
  input  logic [30:0]                            span_x,
  input  logic [30:0]                            span_z,
  input  logic signed [31:0]                     pos_x,
  input  logic signed [31:0]                     pos_z,
  input  logic signed [15:0]                     line_a,
  input  logic signed [15:0]                     line_b,
  input  logic signed [31:0]                     line_offset,
  output logic                                   ram_we,
  output logic [$clog2(GRID_COLS*GRID_ROWS)-1:0] ram_waddr,
  output logic [15:0]                            ram_wdata,
  output logic [$clog2(GRID_COLS*GRID_ROWS)-1:0] ram_raddr,
  input  logic [15:0]                            ram_rdata,
  output logic signed [31:0]                     height,
  output logic                                   on_border
);

  localparam int CELLS = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int GMAX  = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
  localparam int CB    = $clog2(GMAX + 1);
  localparam int DW    = 48 + CB;
  localparam int DCW   = $clog2(DW + 1);
  localparam int ACW   = 16 + CB + 1;
  localparam int SW    = ((ACW + 1 > 32) ? ACW + 1 : 32) + 1;
  localparam int CCW   = DW - 15;
  localparam int PW    = 32 + CB;

  // latched item
  logic signed [31:0] px_r, pz_r, off_r;
  logic signed [15:0] a_r, b_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      px_r  <= pos_x;
      pz_r  <= pos_z;
      a_r   <= line_a;
      b_r   <= line_b;
      off_r <= line_offset;
    end
  end

  // sweep counters and fault line accumulator
  logic [CNTW-1:0]        cnt_r;
  logic [RW-1:0]          row_r;
  logic signed [ACW-1:0]  acc_r, cacc_r;
  logic                   pend_r, up_r;
  logic [AW-1:0]          wa_r;
  logic signed [SW-1:0]   s_w;
  logic                   read_go;

  assign s_w     = (SW'(acc_r) <<< 1) - SW'(off_r);
  assign read_go = cmd.flt_step && (cnt_r != CNTW'(CELLS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else if (cmd.cnt_clr) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else if (cmd.clr_step) begin
      cnt_r <= (cnt_r == CNTW'(CELLS - 1)) ? '0 : cnt_r + CNTW'(1);
    end else if (cmd.flt_step) begin
      pend_r <= read_go;
      if (read_go) begin
        cnt_r <= cnt_r + CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      row_r  <= '0;
      acc_r  <= '0;
      cacc_r <= '0;
    end else if (read_go) begin
      wa_r <= cnt_r[AW-1:0];
      up_r <= (s_w > 0);
      if (row_r == RW'(GRID_ROWS - 1)) begin
        row_r  <= '0;
        cacc_r <= cacc_r + ACW'(a_r);
        acc_r  <= cacc_r + ACW'(a_r);
      end else begin
        row_r <= row_r + RW'(1);
        acc_r <= acc_r + ACW'(b_r);
      end
    end
  end

  // write port: zero on clear, saturating step on fault
  logic signed [15:0] old_w;
  assign old_w     = ram_rdata;
  assign ram_we    = cmd.clr_step || (cmd.flt_step && pend_r);
  assign ram_waddr = cmd.clr_step ? cnt_r[AW-1:0] : wa_r;

  always_comb begin
    if (cmd.clr_step) begin
      ram_wdata = '0;
    end else if (up_r) begin
      ram_wdata = (old_w < flhe_pkg::CELL_MAX) ? old_w + 16'sd1 : old_w;
    end else begin
      ram_wdata = (old_w > flhe_pkg::CELL_MIN) ? old_w - 16'sd1 : old_w;
    end
  end

  // coordinate shift and divider load value
  logic signed [32:0] xs_w, zs_w, ds_w;
  logic [PW-1:0]      prod_w;
  logic [31:0]        dim_w;
  logic [30:0]        dspan_w;

  assign xs_w    = 33'(px_r) + signed'({3'b000, span_x[30:1]});
  assign zs_w    = 33'(pz_r) + signed'({3'b000, span_z[30:1]});
  assign ds_w    = cmd.div_sel ? zs_w : xs_w;
  assign dim_w   = cmd.div_sel ? 32'(GRID_ROWS) : 32'(GRID_COLS);
  assign prod_w  = PW'(ds_w[31:0]) * PW'(dim_w);

  // restoring divider, one quotient bit per cycle
  logic [30:0]     rem_r;
  logic [DW-1:0]   quo_r, qx_r;
  logic [DCW-1:0]  dcnt_r;
  logic            dsel_r;
  logic [31:0]     trial_w;
  logic            take_w;

  assign dspan_w = dsel_r ? span_z : span_x;
  assign trial_w = {rem_r, quo_r[DW-1]};
  assign take_w  = trial_w >= {1'b0, dspan_w};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_load) begin
      dcnt_r <= DCW'(DW);
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r  <= '0;
      quo_r  <= {prod_w, 16'h0000};
      dsel_r <= cmd.div_sel;
    end else if (cmd.div_step) begin
      rem_r <= take_w ? 31'(trial_w - {1'b0, dspan_w}) : trial_w[30:0];
      quo_r <= {quo_r[DW-2:0], take_w};
    end
    if (cmd.div_save_x) begin
      qx_r <= quo_r;
    end
  end

  // rounding, border test, triangle choice
  logic [DW:0]         csum_w, rsum_w;
  logic [CCW-1:0]      cc_w, rc_w;
  logic                bord_w;
  logic signed [15:0]  dc_w, dr_w;
  logic signed [16:0]  dsum_w;
  logic signed [1:0]   c2_w, r2_w, c3_w, r3_w;
  logic [AW-1:0]       base_w;
  logic signed [17:0]  al_w, be_w;

  assign csum_w = {1'b0, qx_r} + (DW + 1)'(32768);
  assign rsum_w = {1'b0, quo_r} + (DW + 1)'(32768);
  assign cc_w   = csum_w[DW:16];
  assign rc_w   = rsum_w[DW:16];
  assign bord_w = (span_x == '0) || (span_z == '0) || xs_w[32] || zs_w[32] ||
                  (cc_w == '0) || (cc_w >= CCW'(GRID_COLS - 1)) ||
                  (rc_w == '0) || (rc_w >= CCW'(GRID_ROWS - 1));
  assign dc_w   = qx_r[15:0];
  assign dr_w   = quo_r[15:0];
  assign dsum_w = 17'(dc_w) + 17'(dr_w);
  assign base_w = AW'(cc_w) * AW'(GRID_ROWS) + AW'(rc_w);

  always_comb begin
    if (dc_w > 0) begin
      if (dr_w > 0) begin
        c2_w = 2'sd1;  r2_w = 2'sd0;  c3_w = 2'sd0;  r3_w = 2'sd1;
      end else if (dsum_w > 0) begin
        c2_w = 2'sd1;  r2_w = -2'sd1; c3_w = 2'sd1;  r3_w = 2'sd0;
      end else begin
        c2_w = 2'sd0;  r2_w = -2'sd1; c3_w = 2'sd1;  r3_w = -2'sd1;
      end
    end else if (dr_w < 0) begin
      c2_w = -2'sd1; r2_w = 2'sd0;  c3_w = 2'sd0;  r3_w = -2'sd1;
    end else if (dsum_w < 0) begin
      c2_w = -2'sd1; r2_w = 2'sd1;  c3_w = -2'sd1; r3_w = 2'sd0;
    end else begin
      c2_w = 2'sd0;  r2_w = 2'sd1;  c3_w = -2'sd1; r3_w = 2'sd1;
    end
  end

  function automatic logic signed [17:0] term(input logic signed [15:0] v,
                                              input logic signed [1:0] k);
    logic signed [17:0] r;
    if (k == 2'sd1) begin
      r = 18'(v);
    end else if (k == -2'sd1) begin
      r = -18'(v);
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] nbr(input logic [AW-1:0] b,
                                        input logic signed [1:0] co,
                                        input logic signed [1:0] ro);
    logic [AW-1:0] s;
    if (co == 2'sd1) begin
      s = b + AW'(GRID_ROWS);
    end else if (co == -2'sd1) begin
      s = b - AW'(GRID_ROWS);
    end else begin
      s = b;
    end
    return s + AW'(ro);
  endfunction

  assign al_w = term(dc_w, r3_w) - term(dr_w, c3_w);
  assign be_w = term(dr_w, c2_w) - term(dc_w, r2_w);

  logic [AW-1:0]       base_r, a2_r, a3_r;
  logic signed [17:0]  al_r, be_r;
  logic signed [15:0]  hc_r, h2_r, h3_r;
  logic signed [34:0]  p1_r, p2_r;
  logic signed [37:0]  res_w;
  logic signed [31:0]  height_r;
  logic                border_r;

  // triangle registers, captured cells and products
  always_ff @(posedge clk) begin
    if (cmd.chk) begin
      base_r <= base_w;
      a2_r   <= nbr(base_w, c2_w, r2_w);
      a3_r   <= nbr(base_w, c3_w, r3_w);
      al_r   <= al_w;
      be_r   <= be_w;
    end
    if (cmd.cap_hc) hc_r <= ram_rdata;
    if (cmd.cap_h2) h2_r <= ram_rdata;
    if (cmd.cap_h3) h3_r <= ram_rdata;
    if (cmd.mul1)   p1_r <= 35'(al_r) * (35'(h2_r) - 35'(hc_r));
    if (cmd.mul2)   p2_r <= 35'(be_r) * (35'(h3_r) - 35'(hc_r));
  end

  assign res_w = (38'(hc_r) <<< 16) + 38'(p1_r) + 38'(p2_r);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      height_r <= '0;
      border_r <= 1'b0;
    end else if (cmd.chk) begin
      border_r <= bord_w;
    end else if (cmd.sum) begin
      if (res_w > 38'sd2147483647) begin
        height_r <= 32'sh7FFFFFFF;
      end else if (res_w < -38'sd2147483648) begin
        height_r <= 32'sh80000000;
      end else begin
        height_r <= res_w[31:0];
      end
    end
  end

  // read address select
  always_comb begin
    if (cmd.flt_step) begin
      ram_raddr = cnt_r[AW-1:0];
    end else begin
      case (cmd.rd_sel)
        flhe_pkg::RD_SECOND: ram_raddr = a2_r;
        flhe_pkg::RD_THIRD:  ram_raddr = a3_r;
        default:             ram_raddr = base_r;
      endcase
    end
  end

  assign sts.sweep_last = (cnt_r == CNTW'(CELLS - 1));
  assign sts.flt_done   = (cnt_r == CNTW'(CELLS)) && !pend_r;
  assign sts.div_done   = (dcnt_r == '0);
  assign sts.border     = bord_w;

  assign height    = height_r;
  assign on_border = border_r;

endmodule

// ----- design/fault_line_heightfield_engine_core.sv -----
// Top level of the fault-line height field engine: config registers and wiring.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  input   | start / busy          | in_op, in_pos_x/z, in_line_a/b/offset
//  result  | out_valid (strobe)    | out_height, out_on_border
//  config  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A clear op sweeps the grid at one cell a cycle.
// A fault op does one read-modify-write a cycle on the single grid RAM.
// A query runs the bit-serial divider twice, then a border check, three RAM
// reads, two multiplies and a sum; a query on the border ends after the check.
// Other ops go straight to the result state and back to idle.
// After rst_n the grid is cleared by a sweep with busy high. Config writes
// are always taken. The receiver cannot stall.
module fault_line_heightfield_engine_core #(
  parameter int GRID_COLS = flhe_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = flhe_pkg::GRID_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_line_a,
  input  logic signed [15:0] in_line_b,
  input  logic signed [31:0] in_line_offset,
  output logic               out_valid,
  output logic signed [31:0] out_height,
  output logic               out_on_border,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int CELLS = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [30:0] span_x_r, span_z_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_x_r <= flhe_pkg::SPAN_RESET;
      span_z_r <= flhe_pkg::SPAN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        flhe_pkg::CFG_SPAN_X: span_x_r <= cfg_data[30:0];
        flhe_pkg::CFG_SPAN_Z: span_z_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  flhe_pkg::cmd_t cmd;
  flhe_pkg::sts_t sts;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  flhe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (in_op),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  flhe_dp #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .span_x      (span_x_r),
    .span_z      (span_z_r),
    .pos_x       (in_pos_x),
    .pos_z       (in_pos_z),
    .line_a      (in_line_a),
    .line_b      (in_line_b),
    .line_offset (in_line_offset),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .height      (out_height),
    .on_border   (out_on_border)
  );

  flhe_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the fault-line height field engine: directed and random ops, checked by a scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = flhe_pkg::GRID_COLS_DEF;
  localparam int ROWS = flhe_pkg::GRID_ROWS_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] CFG_NONE = 2'd2;
  localparam int STALL_LIMIT = 200000;
  localparam logic [31:0] SPAN_MAX = 32'h7FFF_FFFF;

  typedef struct {
    logic signed [31:0] height;
    logic               on_border;
  } height_result_t;

  // Mirror of the grid and span registers; queue of pending results.
  class height_board;
    shortint        grid[COLS*ROWS];
    longint         span_x, span_z;
    height_result_t pending[$];
    int             errors;

    function new();
      span_x = longint'(flhe_pkg::SPAN_RESET);
      span_z = longint'(flhe_pkg::SPAN_RESET);
      errors = 0;
      foreach (grid[k]) grid[k] = 0;
    endfunction

    function void set_span(logic [1:0] idx, logic [31:0] data);
      if (idx == flhe_pkg::CFG_SPAN_X) span_x = longint'(data[30:0]);
      else if (idx == flhe_pkg::CFG_SPAN_Z) span_z = longint'(data[30:0]);
    endfunction

    function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
    endfunction

    function void interpolate(longint px, longint pz, output longint h, output bit brd);
      longint x, z, c, r, cc, rc, dc, dr, hc, h2, h3, al, be, res;
      longint c2, r2, c3, r3;
      h = 0;
      brd = 1;
      if (span_x == 0 || span_z == 0) return;
      x = px + (span_x >> 1);
      z = pz + (span_z >> 1);
      c = floor_div(x * COLS * 65536, span_x);
      r = floor_div(z * ROWS * 65536, span_z);
      if (c < 0 || r < 0) return;
      cc = (c + 32768) >>> 16;
      rc = (r + 32768) >>> 16;
      if (cc < 1 || cc >= COLS - 1 || rc < 1 || rc >= ROWS - 1) return;
      dc = c - cc * 65536;
      dr = r - rc * 65536;
      // pick the triangle around the nearest vertex
      if (dc > 0) begin
        if (dr > 0) begin
          c2 = 1; r2 = 0; c3 = 0; r3 = 1;
        end else if (dc > -dr) begin
          c2 = 1; r2 = -1; c3 = 1; r3 = 0;
        end else begin
          c2 = 0; r2 = -1; c3 = 1; r3 = -1;
        end
      end else if (dr < 0) begin
        c2 = -1; r2 = 0; c3 = 0; r3 = -1;
      end else if (-dc > dr) begin
        c2 = -1; r2 = 1; c3 = -1; r3 = 0;
      end else begin
        c2 = 0; r2 = 1; c3 = -1; r3 = 1;
      end
      hc = grid[cc*ROWS + rc];
      h2 = grid[(cc+c2)*ROWS + rc + r2];
      h3 = grid[(cc+c3)*ROWS + rc + r3];
      al = dc * r3 - dr * c3;
      be = c2 * dr - r2 * dc;
      res = hc * 65536 + al * (h2 - hc) + be * (h3 - hc);
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      h = res;
      brd = 0;
    endfunction

    // Apply one accepted op to the mirror and queue its result.
    function void note_item(logic [1:0] op, logic signed [31:0] px, logic signed [31:0] pz,
                            logic signed [15:0] a, logic signed [15:0] b,
                            logic signed [31:0] off);
      height_result_t exp_r;
      longint h, s;
      bit brd;
      h = 0;
      brd = 0;
      if (op == flhe_pkg::OP_CLEAR) begin
        foreach (grid[k]) grid[k] = 0;
      end else if (op == flhe_pkg::OP_FAULT) begin
        for (int i = 0; i < COLS; i++)
          for (int j = 0; j < ROWS; j++) begin
            s = (longint'(a) * i + longint'(b) * j) * 2 - longint'(off);
            if (s > 0) begin
              if (grid[i*ROWS+j] < flhe_pkg::CELL_MAX) grid[i*ROWS+j]++;
            end else if (grid[i*ROWS+j] > flhe_pkg::CELL_MIN) grid[i*ROWS+j]--;
          end
      end else if (op == flhe_pkg::OP_QUERY) begin
        interpolate(px, pz, h, brd);
      end
      exp_r.height = h[31:0];
      exp_r.on_border = brd;
      pending.push_back(exp_r);
    endfunction

    function void check_result(logic signed [31:0] h, logic brd);
      height_result_t exp_r;
      if (pending.size() == 0) begin
        $error("result with nothing pending: height %0d on_border %0b", h, brd);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (h !== exp_r.height) begin
        $error("height: expected %0d, got %0d", exp_r.height, h);
        errors++;
      end
      if (brd !== exp_r.on_border) begin
        $error("on_border: expected %0b, got %0b", exp_r.on_border, brd);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  logic [1:0]         in_op = flhe_pkg::OP_CLEAR;
  logic signed [31:0] in_pos_x = 0;
  logic signed [31:0] in_pos_z = 0;
  logic signed [15:0] in_line_a = 0;
  logic signed [15:0] in_line_b = 0;
  logic signed [31:0] in_line_offset = 0;
  logic               out_valid;
  logic signed [31:0] out_height;
  logic               out_on_border;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = flhe_pkg::CFG_SPAN_X;
  logic [31:0]        cfg_data = 0;

  height_board board = new();
  int          idle_pct;
  int          stall_cnt;

  fault_line_heightfield_engine_core u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Check every result strobe.
  always @(posedge clk)
    if (rst_n && out_valid) board.check_result(out_height, out_on_border);

  // Count cycles with no transfer on any channel; stop the run at the limit.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic send_op(logic [1:0] op, logic signed [31:0] px, logic signed [31:0] pz,
                         logic signed [15:0] a, logic signed [15:0] b,
                         logic signed [31:0] off);
    // random sender gap
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start = 0;
    end
    @(negedge clk);
    start = 1;
    in_op = op; in_pos_x = px; in_pos_z = pz;
    in_line_a = a; in_line_b = b; in_line_offset = off;
    do @(posedge clk); while (busy);
    board.note_item(op, px, pz, a, b, off);
    @(negedge clk);
    start = 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1; cfg_index = idx; cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    board.set_span(idx, data);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic signed [31:0] pick_pos(longint span);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'(longint'($urandom_range(0, span[31:0])) - (span >>> 1));
  endfunction

  // Mostly queries inside the terrain, with faults, clears and unused ops mixed in.
  task automatic random_ops(int n, int pct);
    int sel;
    logic signed [31:0] off;
    idle_pct = pct;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      off = ($urandom_range(0, 3) == 0) ? $urandom
                                        : 32'($urandom_range(0, 33554432) - 32'd16777216);
      if (sel < 15)
        send_op(flhe_pkg::OP_FAULT, $urandom, $urandom, 16'($urandom), 16'($urandom), off);
      else if (sel < 19)
        send_op(flhe_pkg::OP_CLEAR, $urandom, $urandom, 16'($urandom), 16'($urandom),
                $urandom);
      else if (sel < 23)
        send_op(OP_UNUSED, $urandom, $urandom, 16'($urandom), 16'($urandom), $urandom);
      else
        send_op(flhe_pkg::OP_QUERY, pick_pos(board.span_x), pick_pos(board.span_z),
                16'($urandom), 16'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: flat grid, border extremes, unused op, then shaped terrain
    idle_pct = 0;
    send_op(flhe_pkg::OP_QUERY, 0, 0, 0, 0, 0);
    send_op(flhe_pkg::OP_QUERY, 32'sh7FFF_FFFF, 0, 0, 0, 0);
    send_op(flhe_pkg::OP_QUERY, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0);
    send_op(flhe_pkg::OP_QUERY, 0, 32'sh7FFF_FFFF, 0, 0, 0);
    send_op(OP_UNUSED, -1, -1, -1, -1, -1);
    send_op(flhe_pkg::OP_FAULT, 0, 0, 16'sh7FFF, 16'sh8000, 0);
    send_op(flhe_pkg::OP_FAULT, 0, 0, 16'sh7FFF, 16'sh7FFF, 32'sh7FFF_FFFF);
    send_op(flhe_pkg::OP_FAULT, 0, 0, 16'sh8000, 16'sh1234, 32'sh8000_0000);
    send_op(flhe_pkg::OP_FAULT, 0, 0, 16'sh0400, 16'shF000, -32'sd3000000);
    send_op(flhe_pkg::OP_QUERY, 0, 0, 0, 0, 0);
    send_op(flhe_pkg::OP_QUERY, 32'sh0001_8000, -32'sh0002_4000, 0, 0, 0);
    send_op(flhe_pkg::OP_QUERY, -32'sh0003_3000, 32'sh0000_7000, 0, 0, 0);
    send_op(flhe_pkg::OP_QUERY, 32'sh0010_2000, 32'sh0010_E000, 0, 0, 0);
    send_op(flhe_pkg::OP_QUERY, -32'sh003E_0000, -32'sh003E_0000, 0, 0, 0);
    send_op(flhe_pkg::OP_QUERY, 32'sh003E_7FFF, 32'sh003D_8000, 0, 0, 0);
    send_op(flhe_pkg::OP_QUERY, -32'sh0040_0000, 0, 0, 0, 0);
    send_op(flhe_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
    send_op(flhe_pkg::OP_QUERY, 32'sh0001_8000, -32'sh0002_4000, 0, 0, 0);

    random_ops(20, 26);

    // widest spans
    drain();
    write_cfg(flhe_pkg::CFG_SPAN_X, SPAN_MAX);
    write_cfg(flhe_pkg::CFG_SPAN_Z, 32'hFFFF_FFFF);
    random_ops(10, 26);

    // hold off until every result is back, then narrowest spans
    drain();
    write_cfg(flhe_pkg::CFG_SPAN_X, 1);
    write_cfg(flhe_pkg::CFG_SPAN_Z, 1);
    write_cfg(CFG_NONE, 32'h1234_5678);
    random_ops(8, 63);

    drain();
    write_cfg(flhe_pkg::CFG_SPAN_X, $urandom_range(1 << 20, 1 << 28));
    write_cfg(flhe_pkg::CFG_SPAN_Z, $urandom_range(1 << 20, 1 << 28));
    random_ops(20, 63);

    drain();
    write_cfg(flhe_pkg::CFG_SPAN_X, 32'(flhe_pkg::SPAN_RESET));
    write_cfg(flhe_pkg::CFG_SPAN_Z, 32'(flhe_pkg::SPAN_RESET));
    random_ops(20, 0);

    drain();
    if (board.errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end
endmodule

// ----- files.f -----
design/flhe_pkg.sv
design/flhe_ram.sv
design/flhe_ctrl.sv
design/flhe_dp.sv
design/fault_line_heightfield_engine_core.sv
verif/tb_top.sv
